@@ rtl/core/pfs_pkg.sv @@
// Shared types, constants and micro-operation codes of the priority feedback scheduler.
package pfs_pkg;

	localparam int MAX_TASKS_DEF = 32;

	localparam int ID_W   = 16;
	localparam int PRIO_W = 4;
	localparam int TIME_W = 16;
	localparam int CMD_W  = 3;
	localparam int STAT_W = 2;
	localparam int CFG_AW = 2;

	localparam logic [TIME_W-1:0] TIME_SLICE_RST  = 16'd100;
	localparam logic [PRIO_W-1:0] DEF_PRIO_RST    = 4'd8;
	localparam logic [PRIO_W-1:0] LOWEST_PRIO_RST = 4'd15;

	localparam logic [CFG_AW-1:0] REG_TIME_SLICE  = 2'd0;
	localparam logic [CFG_AW-1:0] REG_DEF_PRIO    = 2'd1;
	localparam logic [CFG_AW-1:0] REG_LOWEST_PRIO = 2'd2;

	localparam logic [CMD_W-1:0] CMD_NEW      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_READY    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd2;
	localparam logic [CMD_W-1:0] CMD_WAIT     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TERM     = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

	typedef logic [4:0] op_t;

	localparam op_t OP_NONE          = 5'd0;
	localparam op_t OP_LOAD          = 5'd1;
	localparam op_t OP_INS_INIT      = 5'd2;
	localparam op_t OP_SET_IDX_ZERO  = 5'd3;
	localparam op_t OP_SET_IDX_RCNT  = 5'd4;
	localparam op_t OP_SET_IDX_CUR   = 5'd5;
	localparam op_t OP_IDX_INC       = 5'd6;
	localparam op_t OP_R_RD_PREV     = 5'd7;
	localparam op_t OP_R_SHIFT_UP    = 5'd8;
	localparam op_t OP_R_PUT         = 5'd9;
	localparam op_t OP_H_RD          = 5'd10;
	localparam op_t OP_H_FOUND       = 5'd11;
	localparam op_t OP_H_PROMOTE     = 5'd12;
	localparam op_t OP_DEMOTE        = 5'd13;
	localparam op_t OP_H_RD_NEXT     = 5'd14;
	localparam op_t OP_H_SHIFT_DN    = 5'd15;
	localparam op_t OP_H_DEC_COUNT   = 5'd16;
	localparam op_t OP_CUR_FIX       = 5'd17;
	localparam op_t OP_CUR_CLR       = 5'd18;
	localparam op_t OP_R_RD_CUR      = 5'd19;
	localparam op_t OP_GRANT         = 5'd20;
	localparam op_t OP_H_RD_PREV     = 5'd21;
	localparam op_t OP_H_SHIFT_UP    = 5'd22;
	localparam op_t OP_H_PUT         = 5'd23;
	localparam op_t OP_R_RD_NEXT     = 5'd24;
	localparam op_t OP_R_SHIFT_DN    = 5'd25;
	localparam op_t OP_R_DEC_COUNT   = 5'd26;
	localparam op_t OP_SET_NOTFOUND  = 5'd27;
	localparam op_t OP_SET_FULL      = 5'd28;
	localparam op_t OP_OUT           = 5'd29;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             cpu_zero;
		logic             r_full;
		logic             h_full;
		logic             cur_ok;
		logic             idx_zero;
		logic             idx_at_hcount;
		logic             h_rem_last;
		logic             r_rem_last;
		logic             cmp_gt;
		logic             match;
		logic             out_busy;
	} dp_status_t;

endpackage

@@ rtl/core/pfs_datapath.sv @@
// Datapath of the scheduler: ready list and held table memories, counters, cursor and result.
module pfs_datapath #(
	parameter int MAX_TASKS = pfs_pkg::MAX_TASKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pfs_pkg::op_t                  op,
	output pfs_pkg::dp_status_t           status,
	input  logic [31:0]                   s_tdata,
	input  logic [pfs_pkg::CMD_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,
	output logic [0:0]                    m_tuser,
	input  logic                          cfg_we,
	input  logic [pfs_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [pfs_pkg::TIME_W-1:0]    cfg_data
);
	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_TASKS);
	localparam logic [CW-1:0] ONE_CNT  = CW'(1);

	logic [pfs_pkg::ID_W-1:0]   r_id_mem [MAX_TASKS];
	logic [pfs_pkg::PRIO_W-1:0] r_pr_mem [MAX_TASKS];
	logic [pfs_pkg::ID_W-1:0]   h_id_mem [MAX_TASKS];
	logic [pfs_pkg::PRIO_W-1:0] h_pr_mem [MAX_TASKS];

	logic [pfs_pkg::ID_W-1:0]   r_rd_id_q, h_rd_id_q;
	logic [pfs_pkg::PRIO_W-1:0] r_rd_pr_q, h_rd_pr_q;

	logic [CW-1:0] rcount_q, hcount_q, idx_q;
	logic [AW-1:0] cursor_q;
	logic          cvalid_q;

	logic [pfs_pkg::TIME_W-1:0] time_slice_q;
	logic [pfs_pkg::PRIO_W-1:0] def_prio_q, lowest_prio_q;

	logic [pfs_pkg::CMD_W-1:0]  cmd_q;
	logic [pfs_pkg::ID_W-1:0]   id_q;
	logic [pfs_pkg::TIME_W-1:0] cpu_q;
	logic [pfs_pkg::PRIO_W-1:0] prio_q;
	logic                       granted_q;
	logic [pfs_pkg::STAT_W-1:0] stat_q;

	logic                       out_valid_q;
	logic [pfs_pkg::ID_W-1:0]   out_gid_q;
	logic                       out_granted_q;
	logic [pfs_pkg::STAT_W-1:0] out_stat_q;

	logic [CW-1:0] idx_prev, idx_next, rcount_dec;
	logic [AW-1:0] a_cur, a_prev, a_next;

	logic                       r_we, r_re, h_we, h_re;
	logic [AW-1:0]              r_waddr, r_raddr, h_waddr, h_raddr;
	logic [pfs_pkg::ID_W-1:0]   r_wid, h_wid;
	logic [pfs_pkg::PRIO_W-1:0] r_wpr, h_wpr;

	assign idx_prev   = idx_q - ONE_CNT;
	assign idx_next   = idx_q + ONE_CNT;
	assign rcount_dec = rcount_q - ONE_CNT;
	assign a_cur      = idx_q[AW-1:0];
	assign a_prev     = idx_prev[AW-1:0];
	assign a_next     = idx_next[AW-1:0];

	always_comb begin
		r_we    = 1'b0;
		r_re    = 1'b0;
		h_we    = 1'b0;
		h_re    = 1'b0;
		r_waddr = a_cur;
		r_raddr = a_cur;
		h_waddr = a_cur;
		h_raddr = a_cur;
		r_wid   = r_rd_id_q;
		r_wpr   = r_rd_pr_q;
		h_wid   = h_rd_id_q;
		h_wpr   = h_rd_pr_q;
		case (op)
			pfs_pkg::OP_R_RD_PREV: begin
				r_re    = 1'b1;
				r_raddr = a_prev;
			end
			pfs_pkg::OP_R_SHIFT_UP: begin
				r_we = 1'b1;
			end
			pfs_pkg::OP_R_PUT: begin
				r_we  = 1'b1;
				r_wid = id_q;
				r_wpr = prio_q;
			end
			pfs_pkg::OP_R_RD_CUR: begin
				r_re    = 1'b1;
				r_raddr = cursor_q;
			end
			pfs_pkg::OP_R_RD_NEXT: begin
				r_re    = 1'b1;
				r_raddr = a_next;
			end
			pfs_pkg::OP_R_SHIFT_DN: begin
				r_we = 1'b1;
			end
			pfs_pkg::OP_H_RD: begin
				h_re = 1'b1;
			end
			pfs_pkg::OP_H_PROMOTE: begin
				h_we  = 1'b1;
				h_wid = id_q;
				h_wpr = (prio_q != '0) ? prio_q - 1'b1 : prio_q;
			end
			pfs_pkg::OP_H_RD_NEXT: begin
				h_re    = 1'b1;
				h_raddr = a_next;
			end
			pfs_pkg::OP_H_SHIFT_DN: begin
				h_we = 1'b1;
			end
			pfs_pkg::OP_H_RD_PREV: begin
				h_re    = 1'b1;
				h_raddr = a_prev;
			end
			pfs_pkg::OP_H_SHIFT_UP: begin
				h_we = 1'b1;
			end
			pfs_pkg::OP_H_PUT: begin
				h_we    = 1'b1;
				h_waddr = '0;
				h_wid   = id_q;
				h_wpr   = prio_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (r_we) begin
			r_id_mem[r_waddr] <= r_wid;
			r_pr_mem[r_waddr] <= r_wpr;
		end
		if (r_re) begin
			r_rd_id_q <= r_id_mem[r_raddr];
			r_rd_pr_q <= r_pr_mem[r_raddr];
		end
		if (h_we) begin
			h_id_mem[h_waddr] <= h_wid;
			h_pr_mem[h_waddr] <= h_wpr;
		end
		if (h_re) begin
			h_rd_id_q <= h_id_mem[h_raddr];
			h_rd_pr_q <= h_pr_mem[h_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_slice_q  <= pfs_pkg::TIME_SLICE_RST;
			def_prio_q    <= pfs_pkg::DEF_PRIO_RST;
			lowest_prio_q <= pfs_pkg::LOWEST_PRIO_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				pfs_pkg::REG_TIME_SLICE:  time_slice_q  <= cfg_data;
				pfs_pkg::REG_DEF_PRIO:    def_prio_q    <= cfg_data[pfs_pkg::PRIO_W-1:0];
				pfs_pkg::REG_LOWEST_PRIO: lowest_prio_q <= cfg_data[pfs_pkg::PRIO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcount_q    <= '0;
			hcount_q    <= '0;
			cursor_q    <= '0;
			cvalid_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (op == pfs_pkg::OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (op)
				pfs_pkg::OP_R_PUT: begin
					rcount_q <= rcount_q + ONE_CNT;
					if (!cvalid_q) begin
						cursor_q <= '0;
						cvalid_q <= 1'b1;
					end else if (CW'(cursor_q) >= idx_q) begin
						cursor_q <= cursor_q + 1'b1;
					end
				end
				pfs_pkg::OP_H_DEC_COUNT: hcount_q <= hcount_q - ONE_CNT;
				pfs_pkg::OP_H_PUT:       hcount_q <= hcount_q + ONE_CNT;
				pfs_pkg::OP_CUR_FIX: begin
					if (!cvalid_q && rcount_q != '0) begin
						cursor_q <= '0;
						cvalid_q <= 1'b1;
					end
				end
				pfs_pkg::OP_CUR_CLR: begin
					cursor_q <= '0;
					cvalid_q <= 1'b0;
				end
				pfs_pkg::OP_R_DEC_COUNT: begin
					rcount_q <= rcount_dec;
					if (CW'(cursor_q) < rcount_dec) begin
						cvalid_q <= 1'b1;
					end else begin
						cvalid_q <= 1'b0;
						cursor_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			pfs_pkg::OP_LOAD: begin
				cmd_q     <= s_tuser;
				id_q      <= s_tdata[15:0];
				cpu_q     <= s_tdata[31:16];
				granted_q <= 1'b0;
				stat_q    <= pfs_pkg::ST_OK;
			end
			pfs_pkg::OP_INS_INIT: begin
				prio_q <= def_prio_q;
				idx_q  <= rcount_q;
			end
			pfs_pkg::OP_SET_IDX_ZERO: idx_q <= '0;
			pfs_pkg::OP_SET_IDX_RCNT: idx_q <= rcount_q;
			pfs_pkg::OP_SET_IDX_CUR:  idx_q <= CW'(cursor_q);
			pfs_pkg::OP_IDX_INC:      idx_q <= idx_next;
			pfs_pkg::OP_R_SHIFT_UP:   idx_q <= idx_prev;
			pfs_pkg::OP_H_SHIFT_UP:   idx_q <= idx_prev;
			pfs_pkg::OP_H_SHIFT_DN:   idx_q <= idx_next;
			pfs_pkg::OP_R_SHIFT_DN:   idx_q <= idx_next;
			pfs_pkg::OP_H_FOUND:      prio_q <= h_rd_pr_q;
			pfs_pkg::OP_DEMOTE: begin
				if (cpu_q >= time_slice_q && prio_q < lowest_prio_q) begin
					prio_q <= prio_q + 1'b1;
				end
			end
			pfs_pkg::OP_GRANT: begin
				id_q      <= r_rd_id_q;
				prio_q    <= r_rd_pr_q;
				granted_q <= 1'b1;
				idx_q     <= hcount_q;
			end
			pfs_pkg::OP_SET_NOTFOUND: stat_q <= pfs_pkg::ST_NOTFOUND;
			pfs_pkg::OP_SET_FULL:     stat_q <= pfs_pkg::ST_FULL;
			pfs_pkg::OP_OUT: begin
				out_gid_q     <= granted_q ? id_q : '0;
				out_granted_q <= granted_q;
				out_stat_q    <= stat_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		status.cmd           = cmd_q;
		status.cpu_zero      = (cpu_q == '0);
		status.r_full        = (rcount_q == FULL_CNT);
		status.h_full        = (hcount_q == FULL_CNT);
		status.cur_ok        = cvalid_q && (CW'(cursor_q) < rcount_q);
		status.idx_zero      = (idx_q == '0);
		status.idx_at_hcount = (idx_q == hcount_q);
		status.h_rem_last    = (idx_next >= hcount_q);
		status.r_rem_last    = (idx_next >= rcount_q);
		status.cmp_gt        = (r_rd_pr_q > prio_q);
		status.match         = (h_rd_id_q == id_q);
		status.out_busy      = out_valid_q && !m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_stat_q, out_gid_q};
	assign m_tuser  = out_granted_q;

endmodule

@@ rtl/core/pfs_ctrl.sv @@
// Controller state machine of the scheduler: sequences the list walks of each command.
module pfs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  pfs_pkg::dp_status_t status,
	output pfs_pkg::op_t        op
);
	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_DEC      = 5'd1;
	localparam logic [4:0] S_FND_CHK  = 5'd2;
	localparam logic [4:0] S_FND_CMP  = 5'd3;
	localparam logic [4:0] S_FOUND    = 5'd4;
	localparam logic [4:0] S_HREM_CHK = 5'd5;
	localparam logic [4:0] S_HREM_W   = 5'd6;
	localparam logic [4:0] S_INS_SET  = 5'd7;
	localparam logic [4:0] S_INS_CHK  = 5'd8;
	localparam logic [4:0] S_INS_CMP  = 5'd9;
	localparam logic [4:0] S_DSP      = 5'd10;
	localparam logic [4:0] S_GRANT    = 5'd11;
	localparam logic [4:0] S_PUSH_CHK = 5'd12;
	localparam logic [4:0] S_PUSH_W   = 5'd13;
	localparam logic [4:0] S_RREM_SET = 5'd14;
	localparam logic [4:0] S_RREM_CHK = 5'd15;
	localparam logic [4:0] S_RREM_W   = 5'd16;
	localparam logic [4:0] S_DONE     = 5'd17;

	logic [4:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		op       = pfs_pkg::OP_NONE;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					op      = pfs_pkg::OP_LOAD;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (status.cmd == pfs_pkg::CMD_NEW ||
				    (status.cmd == pfs_pkg::CMD_READY && status.cpu_zero)) begin
					if (status.r_full) begin
						op      = pfs_pkg::OP_SET_FULL;
						state_d = S_DONE;
					end else begin
						op      = pfs_pkg::OP_INS_INIT;
						state_d = S_INS_CHK;
					end
				end else if (status.cmd == pfs_pkg::CMD_READY ||
				             status.cmd == pfs_pkg::CMD_WAIT ||
				             status.cmd == pfs_pkg::CMD_TERM) begin
					op      = pfs_pkg::OP_SET_IDX_ZERO;
					state_d = S_FND_CHK;
				end else if (status.cmd == pfs_pkg::CMD_DISPATCH) begin
					op      = pfs_pkg::OP_CUR_FIX;
					state_d = S_DSP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_FND_CHK: begin
				if (status.idx_at_hcount) begin
					op      = pfs_pkg::OP_SET_NOTFOUND;
					state_d = S_DONE;
				end else begin
					op      = pfs_pkg::OP_H_RD;
					state_d = S_FND_CMP;
				end
			end
			S_FND_CMP: begin
				if (status.match) begin
					op      = pfs_pkg::OP_H_FOUND;
					state_d = S_FOUND;
				end else begin
					op      = pfs_pkg::OP_IDX_INC;
					state_d = S_FND_CHK;
				end
			end
			S_FOUND: begin
				if (status.cmd == pfs_pkg::CMD_WAIT) begin
					op      = pfs_pkg::OP_H_PROMOTE;
					state_d = S_DONE;
				end else if (status.cmd == pfs_pkg::CMD_TERM) begin
					state_d = S_HREM_CHK;
				end else if (status.r_full) begin
					op      = pfs_pkg::OP_SET_FULL;
					state_d = S_DONE;
				end else begin
					op      = pfs_pkg::OP_DEMOTE;
					state_d = S_HREM_CHK;
				end
			end
			S_HREM_CHK: begin
				if (status.h_rem_last) begin
					op      = pfs_pkg::OP_H_DEC_COUNT;
					state_d = (status.cmd == pfs_pkg::CMD_READY) ? S_INS_SET : S_DONE;
				end else begin
					op      = pfs_pkg::OP_H_RD_NEXT;
					state_d = S_HREM_W;
				end
			end
			S_HREM_W: begin
				op      = pfs_pkg::OP_H_SHIFT_DN;
				state_d = S_HREM_CHK;
			end
			S_INS_SET: begin
				op      = pfs_pkg::OP_SET_IDX_RCNT;
				state_d = S_INS_CHK;
			end
			S_INS_CHK: begin
				if (status.idx_zero) begin
					op      = pfs_pkg::OP_R_PUT;
					state_d = S_DONE;
				end else begin
					op      = pfs_pkg::OP_R_RD_PREV;
					state_d = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (status.cmp_gt) begin
					op      = pfs_pkg::OP_R_SHIFT_UP;
					state_d = S_INS_CHK;
				end else begin
					op      = pfs_pkg::OP_R_PUT;
					state_d = S_DONE;
				end
			end
			S_DSP: begin
				if (!status.cur_ok) begin
					op      = pfs_pkg::OP_CUR_CLR;
					state_d = S_DONE;
				end else if (status.h_full) begin
					op      = pfs_pkg::OP_SET_FULL;
					state_d = S_DONE;
				end else begin
					op      = pfs_pkg::OP_R_RD_CUR;
					state_d = S_GRANT;
				end
			end
			S_GRANT: begin
				op      = pfs_pkg::OP_GRANT;
				state_d = S_PUSH_CHK;
			end
			S_PUSH_CHK: begin
				if (status.idx_zero) begin
					op      = pfs_pkg::OP_H_PUT;
					state_d = S_RREM_SET;
				end else begin
					op      = pfs_pkg::OP_H_RD_PREV;
					state_d = S_PUSH_W;
				end
			end
			S_PUSH_W: begin
				op      = pfs_pkg::OP_H_SHIFT_UP;
				state_d = S_PUSH_CHK;
			end
			S_RREM_SET: begin
				op      = pfs_pkg::OP_SET_IDX_CUR;
				state_d = S_RREM_CHK;
			end
			S_RREM_CHK: begin
				if (status.r_rem_last) begin
					op      = pfs_pkg::OP_R_DEC_COUNT;
					state_d = S_DONE;
				end else begin
					op      = pfs_pkg::OP_R_RD_NEXT;
					state_d = S_RREM_W;
				end
			end
			S_RREM_W: begin
				op      = pfs_pkg::OP_R_SHIFT_DN;
				state_d = S_RREM_CHK;
			end
			S_DONE: begin
				if (!status.out_busy) begin
					op      = pfs_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/priority_feedback_scheduler_unit.sv @@
// Top level of the priority feedback scheduler: controller and datapath.
//
// Commands arrive as beats on the s_ channel: s_tuser carries the command code,
// s_tdata the task ID and the CPU time. Every command beat yields exactly one
// result beat on the m_ channel: granted ID and status in m_tdata, the grant
// flag in m_tuser. The register port writes time slice, default priority and
// lowest priority whenever cfg_we is high; the user must write it only while
// the block is idle, as the block itself does not enforce this.
// One command is worked on at a time. Each step of a walk over the ready list
// or the held table uses the single read port of that memory (read, then
// compare or write back). A ready event walks the held table once, to find the
// task and close its gap, and then walks the ready list to insert it (with zero
// CPU time it is inserted as a new task); a dispatch pushes onto the held table
// and closes the gap in the ready list. The result sits in an output register,
// so a new command is taken while the previous result still waits; a stalled
// receiver holds the block only when a second result is ready to be written.
// Reset empties both lists, drops the cursor and restores the register
// defaults.
module priority_feedback_scheduler_unit #(
	parameter int MAX_TASKS = pfs_pkg::MAX_TASKS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,  // task_id, cpu_time
	input  logic [pfs_pkg::CMD_W-1:0]  s_tuser,  // cmd
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [23:0]                m_tdata,  // granted_id, status
	output logic [0:0]                 m_tuser,  // granted
	input  logic                       cfg_we,
	input  logic [pfs_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [pfs_pkg::TIME_W-1:0] cfg_data
);
	pfs_pkg::op_t        op;
	pfs_pkg::dp_status_t status;

	pfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.op       (op)
	);

	pfs_datapath #(
		.MAX_TASKS (MAX_TASKS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.status   (status),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

endmodule
